@@ hw/rtl/bpfa_pkg.sv @@
`default_nettype none

package bpfa_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned PAGE_W  = 17;
  localparam int unsigned SPAN_W  = 18;

  localparam logic [PAGE_W-1:0] COUNT_MAX   = 17'h1FFFF;
  localparam logic [PAGE_W-1:0] TOTAL_RESET = 17'd65536;

  localparam logic [OP_W-1:0] OP_REQUEST   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
  localparam logic [OP_W-1:0] OP_RESERVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNRESERVE = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  page_index;
    logic [PAGE_W-1:0] page_count;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  alloc_index;
    logic [PAGE_W-1:0] free_pages;
    logic [PAGE_W-1:0] used_pages;
    logic [PAGE_W-1:0] reserved_pages;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic split;
    logic base;
    logic rd;
    logic modify;
    logic acc;
    logic advance;
    logic miss;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic is_req;
    logic hit;
    logic last_word;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpfa_ctrl.sv @@
`default_nettype none

module bpfa_ctrl
  import bpfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      result_valid,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SPLIT = 8'b0000_0100,
    S_BASE  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_MOD   = 8'b0010_0000,
    S_ACC   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = sts.skip ? S_FIN : S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.is_req && sts.hit) begin
          state_next = S_FIN;
        end else if (sts.last_word) begin
          // scan ran off the limit: park the hint there
          cmd.miss   = sts.is_req;
          state_next = S_FIN;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_RD;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_FIN);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpfa_dp.sv @@
`default_nettype none

module bpfa_dp
  import bpfa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [PAGE_W-1:0] cfg_wdata,
  input  wire item_t             item,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output result_t                result
);

  // pages reachable through a 17-bit limit
  localparam int unsigned LIM_MAX   = (MAX_PAGES < 131071) ? MAX_PAGES : 131071;
  localparam int unsigned MAP_WORDS = (LIM_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LW        = $clog2(WORD_BITS);
  localparam int unsigned CW        = $clog2(WORD_BITS + 1);
  localparam int unsigned DIV_SH    = 24;
  localparam int unsigned RECIP     = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RECIP_W   = 22;
  localparam int unsigned PROD_W    = PAGE_W + RECIP_W;

  localparam logic [PAGE_W-1:0]  LIM_V   = PAGE_W'(LIM_MAX);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [SPAN_W-1:0]  WB_V    = SPAN_W'(WORD_BITS);
  localparam logic [AW-1:0]      LAST_W  = AW'(MAP_WORDS - 1);

  function automatic logic [CW-1:0] pop(input logic [WORD_BITS-1:0] v);
    logic [CW-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + CW'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [LW-1:0] lowest(input logic [WORD_BITS-1:0] v);
    logic [LW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LW'(i);
      end
    end
    return idx;
  endfunction

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;

  logic [PAGE_W-1:0]    total;
  logic [PAGE_W-1:0]    hint;
  logic [PAGE_W-1:0]    used;
  logic [PAGE_W-1:0]    reserved;
  logic [OP_W-1:0]      op;
  logic [SPAN_W-1:0]    lo;
  logic [SPAN_W-1:0]    hi;
  logic [PROD_W-1:0]    prod;
  logic [AW-1:0]        addr;
  logic [SPAN_W-1:0]    base;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] vec;
  logic                 found;
  logic [IDX_W-1:0]     grant;

  logic [PAGE_W-1:0]    lim;
  logic [SPAN_W-1:0]    run_end;
  logic [SPAN_W-1:0]    quot;
  logic [WORD_BITS-1:0] mask;
  logic                 is_req;
  logic                 is_set;
  logic [CW-1:0]        n_chg;
  logic [SPAN_W-1:0]    page;
  logic [PAGE_W-1:0]    page17;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] new_word;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [SPAN_W-1:0]    busy_sum;
  logic [PAGE_W-1:0]    free_cnt;
  logic [SPAN_W-1:0]    inc_used;
  logic [SPAN_W-1:0]    inc_res;

  assign lim     = (total > LIM_V) ? LIM_V : total;
  assign run_end = ({2'b0, item.page_index} + {1'b0, item.page_count} > {1'b0, lim})
                 ? {1'b0, lim}
                 : {2'b0, item.page_index} + {1'b0, item.page_count};
  assign quot    = SPAN_W'(prod >> DIV_SH);
  assign is_req  = (op == OP_REQUEST);
  assign is_set  = (op == OP_LOCK) || (op == OP_RESERVE);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = ((base + SPAN_W'(b)) >= lo) && ((base + SPAN_W'(b)) < hi);
    end
  end

  assign n_chg    = pop(vec);
  assign page     = base + SPAN_W'(lowest(vec));
  assign page17   = page[PAGE_W-1:0];
  assign onehot   = vec & (~vec + WORD_BITS'(1));
  assign new_word = is_req ? (word | onehot) : (is_set ? (word | vec) : (word & ~vec));
  assign inc_used = {1'b0, used} + SPAN_W'(is_req ? CW'(1) : n_chg);
  assign inc_res  = {1'b0, reserved} + SPAN_W'(n_chg);

  assign we    = cmd.clear || cmd.acc;
  assign waddr = addr;
  assign wdata = cmd.clear ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= TOTAL_RESET;
      hint     <= '0;
      used     <= '0;
      reserved <= '0;
      addr     <= '0;
    end else begin
      if (cfg_we) begin
        total <= cfg_wdata;
      end
      if (cmd.clear) begin
        addr <= addr + AW'(1);
      end
      if (cmd.base) begin
        addr <= AW'(quot);
      end
      if (cmd.advance) begin
        addr <= addr + AW'(1);
      end
      if (cmd.miss) begin
        hint <= lim;
      end
      if (cmd.acc) begin
        case (op)
          OP_REQUEST: begin
            if (vec != '0) begin
              used <= (inc_used > {1'b0, COUNT_MAX}) ? COUNT_MAX : inc_used[PAGE_W-1:0];
              hint <= page17;
            end
          end
          OP_LOCK: begin
            used <= (inc_used > {1'b0, COUNT_MAX}) ? COUNT_MAX : inc_used[PAGE_W-1:0];
          end
          OP_RESERVE: begin
            reserved <= (inc_res > {1'b0, COUNT_MAX}) ? COUNT_MAX : inc_res[PAGE_W-1:0];
          end
          OP_FREE: begin
            used <= (used > PAGE_W'(n_chg)) ? used - PAGE_W'(n_chg) : '0;
            if (vec != '0 && hint > page17) begin
              hint <= page17;
            end
          end
          OP_UNRESERVE: begin
            reserved <= (reserved > PAGE_W'(n_chg)) ? reserved - PAGE_W'(n_chg) : '0;
            if (vec != '0 && hint > page17) begin
              hint <= page17;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= item.op;
      found <= (item.op != OP_REQUEST);
      grant <= '0;
      if (item.op == OP_REQUEST) begin
        lo <= {1'b0, hint};
        hi <= {1'b0, lim};
      end else begin
        lo <= {2'b0, item.page_index};
        hi <= run_end;
      end
    end
    if (cmd.split) begin
      prod <= lo[PAGE_W-1:0] * RECIP_V;
    end
    if (cmd.base) begin
      base <= SPAN_W'(quot * WB_V);
    end
    if (cmd.advance) begin
      base <= base + WB_V;
    end
    if (cmd.modify) begin
      word <= rdata;
      vec  <= (is_req || is_set) ? (~rdata & mask) : (rdata & mask);
    end
    if (cmd.acc && is_req && vec != '0) begin
      found <= 1'b1;
      grant <= page[IDX_W-1:0];
    end
    if (cmd.finish) begin
      result.found          <= found;
      result.alloc_index    <= grant;
      result.free_pages     <= free_cnt;
      result.used_pages     <= used;
      result.reserved_pages <= reserved;
    end
  end

  assign busy_sum = {1'b0, used} + {1'b0, reserved};
  assign free_cnt = ({1'b0, lim} > busy_sum) ? lim - busy_sum[PAGE_W-1:0] : '0;

  assign sts.clear_last = (addr == LAST_W);
  assign sts.skip       = (op > OP_UNRESERVE) || (lo >= hi);
  assign sts.is_req     = is_req;
  assign sts.hit        = (vec != '0);
  assign sts.last_word  = (base + WB_V >= hi);

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_frame_allocator.sv @@
`default_nettype none

// Bitmap page frame allocator with next-fit search.
//
// Commands enter on item when start is high and busy is low. Request grants
// the first clear page at or above the search hint; free, lock, reserve and
// unreserve act on a run of page_count pages from page_index. Every
// transaction returns one result on result, marked by a one-cycle
// result_valid strobe; the receiver cannot stall it.
// The user must write the page limit total_pages through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this. An empty run or
// unknown op skips the bitmap scan; otherwise each visited bitmap word
// takes a read, a modify and a write-back on the single bitmap RAM.
// A new transaction may be accepted in the cycle of the strobe.
// After reset the bitmap RAM is cleared one word a cycle, all MAP_WORDS
// words (1024 with the defaults), with busy high; counters and hint reset
// to zero, total_pages to 65536.

module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 65536,
  parameter int unsigned WORD_BITS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire item_t             item,
  output logic                   result_valid,
  output result_t                result,
  input  wire logic              cfg_we,
  input  wire logic [PAGE_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd),
    .sts          (sts)
  );

  bpfa_dp #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

`default_nettype wire
